@@ rtl/integer_to_ascii_formatter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit assertion macros
// Shorthand for clocked implications, reset-qualified on aresetn.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

// same-cycle implication
`define ITFA_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ITFA_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/itfa_pkg.sv @@
// ----------------------------------------------------------------------------
// itfa_pkg
// Shared types, constants and helpers of the integer to ascii formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itfa_pkg;

    localparam int VALUE_W    = 64;
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int CNT_W      = 6;

    localparam logic [FUNC_W-1:0] FUNC_HEX    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEC    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEC_NL = 2'd2;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_DIGITS,
        S_HEX,
        S_NL
    } itfa_state_t;

    // control handed along the digit chain
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic dig_shift;
    } itfa_cell_ctrl_t;

    // upper-case hex character of one nibble
    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {3'd0, nib};
        end else begin
            c = CH_UPPER_A + {3'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/itfa_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// itfa_bcd_cell
// One decimal digit of the shift-add-3 converter; also shifts digit-wise.
// ----------------------------------------------------------------------------
`default_nettype none

module itfa_bcd_cell (
    input  wire                            aclk,
    input  itfa_pkg::itfa_cell_ctrl_t      ctrl,
    input  wire                            bit_in,
    input  wire  [itfa_pkg::DIGIT_W-1:0]   digit_in,
    output logic [itfa_pkg::DIGIT_W-1:0]   digit,
    output logic                           bit_out
);
    import itfa_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // add 3 when the digit would overflow after doubling
    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[DIGIT_W-1];
    assign digit   = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.bit_shift) begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end else if (ctrl.dig_shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

@@ rtl/itfa_bcd_chain.sv @@
// ----------------------------------------------------------------------------
// itfa_bcd_chain
// Row of BCD cells: binary bits enter at the low end, digits leave at the top.
// ----------------------------------------------------------------------------
`default_nettype none

module itfa_bcd_chain (
    input  wire                            aclk,
    input  itfa_pkg::itfa_cell_ctrl_t      ctrl,
    input  wire                            bit_in,
    output logic [itfa_pkg::DIGIT_W-1:0]   top_digit,
    output logic                           carry_out
);
    import itfa_pkg::*;

    logic [DIGIT_W-1:0] dig_w [DEC_DIGITS];
    logic               bit_w [DEC_DIGITS];

    // each cell takes bits and digits from its lower neighbor
    for (genvar i = 0; i < DEC_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_low
            itfa_bcd_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .bit_in   (bit_in),
                .digit_in ('0),
                .digit    (dig_w[i]),
                .bit_out  (bit_w[i])
            );
        end else begin : g_mid
            itfa_bcd_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .bit_in   (bit_w[i-1]),
                .digit_in (dig_w[i-1]),
                .digit    (dig_w[i]),
                .bit_out  (bit_w[i])
            );
        end
    end

    assign top_digit = dig_w[DEC_DIGITS-1];
    assign carry_out = bit_w[DEC_DIGITS-1];

endmodule

`default_nettype wire

@@ rtl/integer_to_ascii_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Prints a 64-bit value as ASCII hex or signed decimal, one char per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction carries the value in s_tdata and the mode in
//   s_tuser (0 hex + newline, 1 signed decimal, 2 signed decimal + newline,
//   3 ignored). s_tready is high only while the unit is idle.
//   m_ channel: one character per transaction in m_tdata[6:0], m_tlast on the
//   final character of the item.
// Sequence:
//   hex: 17 characters (16 digits and a newline), one per cycle while m_tready
//   does not stall; the first is loaded into the output register in S_HEX,
//   the state that follows the input transaction. decimal: bit-serial
//   conversion of all 64 bits in the digit chain (S_CONV), a minus sign if
//   negative (S_SIGN), then leading zero digits are skipped (S_SKIP) and the
//   remaining digits emitted (S_DIGITS), then a newline if asked (S_NL).
//   The next item is accepted as soon as the last character sits in the
//   output register.
// Reset: aresetn low clears the sequencer and the output valid; no clearing
//   pass. Stall: while a character is held with m_tready low, the output
//   register holds and no further character is loaded; none is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_formatter_unit_assert.svh"

module integer_to_ascii_formatter_unit (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [itfa_pkg::VALUE_W-1:0]    s_tdata,   // [63:0] value
    input  wire  [itfa_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [7:0]                      m_tdata,   // [6:0] char_code, [7] zero
    output logic                            m_tlast    // last_char
);
    import itfa_pkg::*;

    itfa_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  data_reg, data_next;
    logic                neg_reg, neg_next;
    logic                nl_reg, nl_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;

    logic                out_free;
    logic                s_accept;
    logic [VALUE_W-1:0]  mag;
    itfa_cell_ctrl_t     cell_ctrl;
    logic [DIGIT_W-1:0]  top_digit;
    logic                chain_carry;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign mag      = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

    // decimal digit chain
    itfa_bcd_chain u_chain (
        .aclk      (aclk),
        .ctrl      (cell_ctrl),
        .bit_in    (data_reg[VALUE_W-1]),
        .top_digit (top_digit),
        .carry_out (chain_carry)
    );

    // sequencer next state and output register loading
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        data_next     = data_reg;
        neg_next      = neg_reg;
        nl_next       = nl_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        cell_ctrl     = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        FUNC_HEX: begin
                            data_next  = s_tdata;
                            cnt_next   = CNT_W'(HEX_DIGITS - 1);
                            state_next = S_HEX;
                        end
                        FUNC_DEC, FUNC_DEC_NL: begin
                            data_next       = mag;
                            neg_next        = s_tdata[VALUE_W-1];
                            nl_next         = (s_tuser == FUNC_DEC_NL);
                            cnt_next        = CNT_W'(VALUE_W - 1);
                            cell_ctrl.clear = 1'b1;
                            state_next      = S_CONV;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                cell_ctrl.bit_shift = 1'b1;
                data_next           = {data_reg[VALUE_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    cnt_next   = CNT_W'(DEC_DIGITS - 1);
                    state_next = neg_reg ? S_SIGN : S_SKIP;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = CH_MINUS;
                    m_last_next   = 1'b0;
                    state_next    = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (top_digit == '0 && cnt_reg != '0) begin
                    cell_ctrl.dig_shift = 1'b1;
                    cnt_next            = cnt_reg - 1'b1;
                end else begin
                    state_next = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (out_free) begin
                    m_tvalid_next       = 1'b1;
                    m_char_next         = CH_ZERO + {3'd0, top_digit};
                    m_last_next         = !nl_reg && (cnt_reg == '0);
                    cell_ctrl.dig_shift = 1'b1;
                    if (cnt_reg == '0) begin
                        state_next = nl_reg ? S_NL : S_IDLE;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            S_HEX: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = hex_char(data_reg[VALUE_W-1 -: DIGIT_W]);
                    m_last_next   = 1'b0;
                    data_next     = {data_reg[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    if (cnt_reg == '0) begin
                        state_next = S_NL;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            S_NL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = CH_NEWLINE;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        data_reg   <= data_next;
        neg_reg    <= neg_next;
        nl_reg     <= nl_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    // assertions
    `ITFA_ASSERT_NEXT(a_hex_start, aclk, aresetn, s_accept && s_tuser == FUNC_HEX,
        state_reg == S_HEX, "hex item did not start hex output")
    `ITFA_ASSERT_NEXT(a_conv_end, aclk, aresetn, state_reg == S_CONV && cnt_reg == '0,
        state_reg == S_SIGN || state_reg == S_SKIP, "conversion did not end after 64 bits")
    `ITFA_ASSERT_NOW(a_no_overflow, aclk, aresetn, state_reg == S_CONV,
        !chain_carry, "digit chain overflowed")
    `ITFA_ASSERT_NOW(a_last_char, aclk, aresetn, m_tvalid && m_tlast,
        m_char_reg == CH_NEWLINE || (m_char_reg >= CH_ZERO && m_char_reg <= CH_NINE),
        "final character is neither newline nor digit")

endmodule

`default_nettype wire
